// ----- rtl/core/vsru_pkg.sv -----
// Shared types and constants for the video scanline register unit.
// No dependencies; imported by vsru_line_timer and the core top level.
`default_nettype none

package vsru_pkg;

  localparam int unsigned REG_COUNT = 14;
  localparam int unsigned REG_IDX_W = 4;   // address bits 5:2
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACC_W     = 17;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned FRAME_W   = 10;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] CMP_REG  = 4'd3;
  localparam logic [REG_IDX_W-1:0] LINE_REG = 4'd4;

  localparam logic [ACC_W-1:0]    ACC_MAX          = 17'h1FFFF;
  localparam logic [PERIOD_W-1:0] LINE_PERIOD_RST  = 16'd548;
  localparam logic [FRAME_W-1:0]  LINES_FRAME_RST  = 10'd525;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = 2'd1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  // Outcome of one tick, handed from the line timer to the core.
  typedef struct packed {
    logic              advance;   // accumulator reached one line period
    logic              hit;       // advanced line equals compare register
    logic              wrap;      // advanced line at or past frame length
    logic [ACC_W-1:0]  acc_next;
    logic [DATA_W-1:0] line_next;
  } tick_res_t;

endpackage : vsru_pkg

`default_nettype wire

// ----- rtl/core/video_scanline_register_unit_core.sv -----
// Video scanline register unit: register file, scanline counter, line IRQ.
// Depends on vsru_pkg and vsru_line_timer.
`default_nettype none

// Channel  Signals                                        Direction
// -------  ---------------------------------------------  ---------
// in       in_valid/in_stall, kind, reg_address,          request in
//          write_data, elapsed_cycles
// out      out_valid/out_stall, read_data,                request out
//          line_interrupt, frame_end
// cfg      cfg_we, cfg_index, cfg_data                    write only
//
// One request per cycle sustained while out_stall is low. Each request
// passes the input register, then the result register, whose load raises
// out_valid. The state update (register file, accumulator, line counter,
// IRQ) is committed on the same edge the result register loads, so each
// request sees all earlier ones. rst is synchronous: registers zero,
// accumulator zero, IRQ clear, config back to line period 548 and frame
// length 525. A stalled result holds the result register; the input
// register refills only as the result drains.

module video_scanline_register_unit_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request in
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     kind,
  input  wire logic [5:0]                     reg_address,
  input  wire logic [vsru_pkg::DATA_W-1:0]    write_data,
  input  wire logic [vsru_pkg::ELAPSED_W-1:0] elapsed_cycles,
  // request out
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [vsru_pkg::DATA_W-1:0]         read_data,
  output logic                                line_interrupt,
  output logic                                frame_end,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [vsru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vsru_pkg::PERIOD_W-1:0]  cfg_data
);
  import vsru_pkg::*;

  // configuration registers
  logic [PERIOD_W-1:0] line_period;
  logic [FRAME_W-1:0]  lines_per_frame;

  // input register
  logic                 s1_valid;
  logic [1:0]           s1_kind;
  logic [REG_IDX_W-1:0] s1_idx;
  logic [DATA_W-1:0]    s1_wdata;
  logic [ELAPSED_W-1:0] s1_elapsed;

  // architectural state
  logic [DATA_W-1:0] regs [REG_COUNT];
  logic [ACC_W-1:0]  acc;
  logic              irq_pending;

  logic              adv;        // s1 moves into the result register
  logic              idx_ok;
  tick_res_t         tick_res;

  // next-state terms
  logic [DATA_W-1:0] rdata_next;
  logic              fend_next;
  logic              irq_next;
  logic [ACC_W-1:0]  acc_next;
  logic              do_write;
  logic              do_tick_line;

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign idx_ok   = ({1'b0, s1_idx} < (REG_IDX_W+1)'(REG_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_period     <= LINE_PERIOD_RST;
      lines_per_frame <= LINES_FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_PERIOD:     line_period     <= cfg_data;
        CFG_LINES_PER_FRAME: lines_per_frame <= cfg_data[FRAME_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  vsru_line_timer u_line_timer (
    .acc             (acc),
    .elapsed         (s1_elapsed),
    .line_period     (line_period),
    .lines_per_frame (lines_per_frame),
    .line            (regs[LINE_REG]),
    .line_cmp        (regs[CMP_REG]),
    .res             (tick_res)
  );

  // Per-kind decode of the request held in s1.
  always_comb begin
    rdata_next   = '0;
    fend_next    = 1'b0;
    irq_next     = irq_pending;
    acc_next     = acc;
    do_write     = 1'b0;
    do_tick_line = 1'b0;
    unique case (s1_kind)
      KIND_WRITE: begin
        if (idx_ok) begin
          if (s1_idx == LINE_REG) begin
            irq_next = 1'b0;      // write to line register acks the IRQ
          end else begin
            do_write = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (idx_ok) begin
          rdata_next = regs[s1_idx];
        end
      end
      KIND_TICK: begin
        acc_next = tick_res.acc_next;
        if (tick_res.advance) begin
          do_tick_line = 1'b1;
          fend_next    = tick_res.wrap;
          if (tick_res.hit) begin
            irq_next = 1'b1;
          end
        end
      end
      default: ;  // unused kind: no effect
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind    <= kind;
      s1_idx     <= reg_address[5:2];
      s1_wdata   <= write_data;
      s1_elapsed <= elapsed_cycles;
    end
  end

  // state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= '0;
      end
      acc         <= '0;
      irq_pending <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (do_write && (s1_idx == REG_IDX_W'(i))) begin
          regs[i] <= s1_wdata;
        end
      end
      if (do_tick_line) begin
        regs[LINE_REG] <= tick_res.line_next;
      end
      acc         <= acc_next;
      irq_pending <= irq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data      <= rdata_next;
      line_interrupt <= irq_next;
      frame_end      <= fend_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions

  // A held-off input always means a request is parked in s1.
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall without a parked request");

  // A wrapping tick leaves the line at zero and flags end of frame.
  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && do_tick_line && tick_res.wrap) |=>
      (regs[LINE_REG] == '0) && frame_end && out_valid)
    else $error("frame wrap did not clear the line counter");

  // A write to the line register acknowledges the interrupt.
  a_irq_ack: assert property (@(posedge clk) disable iff (rst)
    (adv && (s1_kind == KIND_WRITE) && (s1_idx == LINE_REG)) |=>
      !irq_pending && !line_interrupt)
    else $error("line register write did not clear the interrupt");

  // The reported interrupt flag mirrors the pending state it was taken from.
  a_irq_mirror: assert property (@(posedge clk) disable iff (rst)
    adv |=> (line_interrupt == irq_pending))
    else $error("line_interrupt out of step with pending state");

endmodule : video_scanline_register_unit_core

`default_nettype wire

// ----- rtl/core/vsru_line_timer.sv -----
// Scanline timing step: accumulate cycles, advance and wrap the line counter.
// Depends on vsru_pkg. Pure combinational logic.
`default_nettype none

module vsru_line_timer (
  input  wire logic [vsru_pkg::ACC_W-1:0]     acc,
  input  wire logic [vsru_pkg::ELAPSED_W-1:0] elapsed,
  input  wire logic [vsru_pkg::PERIOD_W-1:0]  line_period,
  input  wire logic [vsru_pkg::FRAME_W-1:0]   lines_per_frame,
  input  wire logic [vsru_pkg::DATA_W-1:0]    line,
  input  wire logic [vsru_pkg::DATA_W-1:0]    line_cmp,
  output vsru_pkg::tick_res_t                 res
);
  import vsru_pkg::*;

  logic [ACC_W:0]    sum_wide;
  logic [ACC_W-1:0]  sum_sat;
  logic [ACC_W-1:0]  period_ext;
  logic [DATA_W-1:0] line_inc;

  assign sum_wide   = {1'b0, acc} + {{(ACC_W+1-ELAPSED_W){1'b0}}, elapsed};
  // saturate, at most one line per tick
  assign sum_sat    = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];
  assign period_ext = {{(ACC_W-PERIOD_W){1'b0}}, line_period};
  assign line_inc   = line + {{(DATA_W-1){1'b0}}, 1'b1};

  always_comb begin
    res.advance   = (sum_sat >= period_ext);
    res.acc_next  = res.advance ? (sum_sat - period_ext) : sum_sat;
    res.hit       = (line_inc == line_cmp);
    res.wrap      = (line_inc >= {{(DATA_W-FRAME_W){1'b0}}, lines_per_frame});
    res.line_next = res.wrap ? '0 : line_inc;
  end

endmodule : vsru_line_timer

`default_nettype wire

// ----- bench/scanline_checker.sv -----
// Checker for the video scanline register unit: tracks registers, accumulator and IRQ.
// Watches the request and config ports, queues predicted results, compares outputs.
// Depends on vsru_pkg.
`timescale 1ns / 100ps

module scanline_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [5:0]                     reg_address,
  input  logic [vsru_pkg::DATA_W-1:0]    write_data,
  input  logic [vsru_pkg::ELAPSED_W-1:0] elapsed_cycles,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [vsru_pkg::DATA_W-1:0]    read_data,
  input  logic                           line_interrupt,
  input  logic                           frame_end,
  input  logic                           cfg_we,
  input  logic [vsru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vsru_pkg::PERIOD_W-1:0]  cfg_data,
  output int                             mismatches,
  output int                             waiting
);
  import vsru_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq;
    logic              fend;
  } scan_result_t;

  logic [DATA_W-1:0]   bank [REG_COUNT];
  logic [ACC_W-1:0]    acc;
  logic                irq_pending;
  logic [PERIOD_W-1:0] period;
  logic [FRAME_W-1:0]  frame_len;

  scan_result_t scan_results_due [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Applies one request to the tracked state and returns its result.
  function automatic scan_result_t step_scanline(input logic [1:0] k,
                                                 input logic [5:0] addr,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic [ELAPSED_W-1:0] elapsed);
    scan_result_t       r;
    logic [3:0]         idx;
    logic [ACC_W:0]     sum;
    logic [DATA_W-1:0]  line;
    r   = '0;
    idx = addr[5:2];
    case (k)
      KIND_WRITE: begin
        if (idx < REG_COUNT) begin
          if (idx == LINE_REG) irq_pending = 1'b0;
          else bank[idx] = data;
        end
      end
      KIND_READ: begin
        if (idx < REG_COUNT) r.rdata = bank[idx];
      end
      KIND_TICK: begin
        sum = {1'b0, acc} + elapsed;
        if (sum > ACC_MAX) sum = ACC_MAX;
        if (sum >= period) begin
          sum  = sum - period;
          line = bank[LINE_REG] + 1;
          // compare uses the advanced line, before any wrap
          if (line == bank[CMP_REG]) irq_pending = 1'b1;
          if (line >= frame_len) begin
            line   = '0;
            r.fend = 1'b1;
          end
          bank[LINE_REG] = line;
        end
        acc = sum[ACC_W-1:0];
      end
      default: ;
    endcase
    r.irq = irq_pending;
    return r;
  endfunction

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) bank[i] = '0;
      acc         = '0;
      irq_pending = 1'b0;
      period      = LINE_PERIOD_RST;
      frame_len   = LINES_FRAME_RST;
      scan_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (scan_results_due.size() == 0) begin
          report_mismatch("result with no request pending", read_data, '0);
        end else begin
          want = scan_results_due.pop_front();
          if (read_data !== want.rdata)
            report_mismatch("read_data", read_data, want.rdata);
          if (line_interrupt !== want.irq)
            report_mismatch("line_interrupt", line_interrupt, want.irq);
          if (frame_end !== want.fend)
            report_mismatch("frame_end", frame_end, want.fend);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_PERIOD:     period    = cfg_data;
          CFG_LINES_PER_FRAME: frame_len = cfg_data[FRAME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        scan_results_due.push_back(step_scanline(kind, reg_address, write_data,
                                                 elapsed_cycles));
    end
    waiting <= scan_results_due.size();
  end

endmodule

// ----- bench/video_scanline_register_unit_core_test.sv -----
// Testbench top for video_scanline_register_unit_core: drives requests and timing config.
// Depends on vsru_pkg, the core, and scanline_checker for prediction and compare.
`timescale 1ns / 100ps

module video_scanline_register_unit_core_test;
  import vsru_pkg::*;

  // kind 3 is not decoded by the block; it must leave all state alone
  localparam logic [1:0]           KIND_SPARE   = 2'd3;
  // config indexes past the two timing registers
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 115;
  localparam int HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           kind = '0;
  logic [5:0]           reg_address = '0;
  logic [DATA_W-1:0]    write_data = '0;
  logic [ELAPSED_W-1:0] elapsed_cycles = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    read_data;
  logic                 line_interrupt;
  logic                 frame_end;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0]  cfg_data = '0;

  int   mismatches;
  int   waiting;
  int   quiet_cycles = 0;
  bit   idle_gaps = 1'b1;   // random gaps on both sides; cleared for the last phase
  logic hold_now = 1'b0;    // asks the result side for one long hold-off
  int   cur_period = LINE_PERIOD_RST;
  int   cur_frame  = LINES_FRAME_RST;

  video_scanline_register_unit_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .reg_address    (reg_address),
    .write_data     (write_data),
    .elapsed_cycles (elapsed_cycles),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .line_interrupt (line_interrupt),
    .frame_end      (frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  scanline_checker scan_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .reg_address    (reg_address),
    .write_data     (write_data),
    .elapsed_cycles (elapsed_cycles),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .line_interrupt (line_interrupt),
    .frame_end      (frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .waiting        (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any stretch without a handshake on either channel counts.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side pacing: random stall bursts, plus one long hold-off on request.
  // The hold is counted here so the sender keeps offering and the block backs up.
  initial begin : result_pacing
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        hold_now  <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_gaps && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one request, with an optional idle burst ahead of it, and returns on
  // the edge that accepts it. in_valid stays high for back-to-back requests.
  task automatic send_request(input logic [1:0] k, input logic [5:0] a,
                              input logic [DATA_W-1:0] d,
                              input logic [ELAPSED_W-1:0] e);
    if (idle_gaps && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    reg_address    <= a;
    write_data     <= d;
    elapsed_cycles <= e;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every predicted result has been taken.
  // The first edge lets the checker count a request accepted on the last edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (2) @(posedge clk);   // covers the two-stage pipeline
  endtask

  // Writes both timing registers, then both unused indexes with junk.
  task automatic load_timing(input logic [PERIOD_W-1:0] period,
                             input logic [PERIOD_W-1:0] frame_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LINE_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= CFG_LINES_PER_FRAME;
    cfg_data  <= frame_word;   // only the low 10 bits count
    @(posedge clk);
    cfg_index <= CFG_SPARE_LO;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_index <= CFG_SPARE_HI;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_period = period;
    cur_frame  = frame_word[FRAME_W-1:0];
  endtask

  // Random request, weighted toward ticks and compare/line register traffic so
  // lines advance, compares hit and interrupts get acknowledged. Unused fields
  // carry random values; the block must ignore them.
  task automatic send_random();
    int                   pick;
    int                   cap;
    int                   cmp_span;
    logic [1:0]           k;
    logic [5:0]           a;
    logic [DATA_W-1:0]    d;
    logic [ELAPSED_W-1:0] e;
    pick     = $urandom_range(0, 99);
    a        = 6'($urandom);
    d        = $urandom;
    e        = 16'($urandom);
    cap      = cur_period * 2;
    cmp_span = (cur_frame > 60) ? 60 : cur_frame + 1;
    if (pick < 45) begin
      k = KIND_TICK;
      case ($urandom_range(0, 9))
        0:       e = 16'hFFFF;
        1:       e = '0;
        2, 3, 4: ;
        default: if (cap > 0 && cap < 65536) e = 16'($urandom_range(0, cap));
      endcase
    end else if (pick < 67) begin
      k = KIND_WRITE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = {CMP_REG, 2'($urandom_range(0, 3))};
          if ($urandom_range(0, 7) != 0) d = $urandom_range(0, cmp_span);
        end
        4, 5: a = {LINE_REG, 2'($urandom_range(0, 3))};   // acknowledge
        default: ;
      endcase
    end else if (pick < 95) begin
      k = KIND_READ;
      if ($urandom_range(0, 9) < 4) a = {LINE_REG, 2'($urandom_range(0, 3))};
    end else begin
      k = KIND_SPARE;
    end
    send_request(k, a, d, e);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset timing (line period 548, 525 lines).
    send_request(KIND_WRITE, 6'h00, 32'hFFFF_FFFF, 16'h0000);
    send_request(KIND_READ,  6'h03, 32'h0000_0000, 16'hFFFF);  // same reg, odd byte lane
    send_request(KIND_WRITE, 6'h37, 32'hA5A5_5A5A, 16'h0000);  // last implemented reg
    send_request(KIND_READ,  6'h34, 32'h0000_0000, 16'h0000);
    send_request(KIND_WRITE, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);  // unimplemented: dropped
    send_request(KIND_READ,  6'h3C, 32'hFFFF_FFFF, 16'h0000);  // unimplemented reads zero
    send_request(KIND_READ,  6'h38, 32'h0000_0000, 16'h0000);
    send_request(KIND_WRITE, {CMP_REG, 2'd0}, 32'd2, 16'h0000);
    send_request(KIND_TICK,  6'h00, 32'h0000_0000, 16'hFFFF);  // line 1
    send_request(KIND_TICK,  6'h3F, 32'hFFFF_FFFF, 16'hFFFF);  // line 2 hits compare
    send_request(KIND_TICK,  6'h00, 32'h0000_0000, 16'hFFFF);  // accumulator saturates
    send_request(KIND_SPARE, 6'h10, 32'hFFFF_FFFF, 16'hFFFF);  // no effect
    send_request(KIND_READ,  {LINE_REG, 2'd1}, 32'h0, 16'h0);
    send_request(KIND_WRITE, {LINE_REG, 2'd0}, 32'hFFFF_FFFF, 16'h0);  // ack, no store
    send_request(KIND_READ,  {LINE_REG, 2'd0}, 32'h0, 16'h0);
    send_request(KIND_TICK,  6'h00, 32'h0000_0000, 16'h0000);  // leftover still advances
    send_request(KIND_READ,  {CMP_REG, 2'd3}, 32'h0, 16'h0);
    send_request(KIND_WRITE, 6'h00, 32'h0000_0000, 16'h0000);
    send_request(KIND_READ,  6'h01, 32'hFFFF_FFFF, 16'hFFFF);

    // Random phases, each under its own timing. Config only changes once drained.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      case (p)
        0: load_timing(16'd0, 16'd3);           // zero period: a line per tick
        1: load_timing(16'd700, 16'd200);
        2: load_timing(16'd20, 16'hFC00);       // frame length masks to zero
        3: load_timing(16'hFFFF, 16'd1023);     // largest period and frame
        4: load_timing(16'd1, 16'd1);           // lowered frame wraps at once
        default: begin
          idle_gaps = 1'b0;                     // last phase runs flat out
          load_timing(16'($urandom_range(1, 300)), 16'($urandom_range(2, 40)));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 30) hold_now <= 1'b1;   // back the block up
        if (p == 2 && n == 60) drain();            // sender pause to empty
        send_random();
      end
    end

    drain();
    repeat (3) @(posedge clk);
    if (mismatches == 0 && waiting == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
